// ===== rtl/core/cmri_frame_parser_macros.svh =====
// Assertion macros for the CMRI frame parser.
// The clock is clk_i and the asynchronous active-low reset is rst_ni.
`ifndef CMRI_FRAME_PARSER_MACROS_SVH
`define CMRI_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define CMRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CMRI_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CMRI_ASSERT(lbl, prop, msg)
`define CMRI_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/cmri_pkg.sv =====
// Shared types and constants for the CMRI frame parser.
// Used by the result interface, the register block, the parser core and the top level.
package cmri_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned POS_OUT_BITS  = 16;
  localparam int unsigned ADDR_BITS     = 5;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_INIT = 3'd1;
  localparam logic [2:0] EV_POLL = 3'd2;
  localparam logic [2:0] EV_XMIT = 3'd3;
  localparam logic [2:0] EV_DATA = 3'd4;
  localparam logic [2:0] EV_END  = 3'd5;
  localparam logic [2:0] EV_ERR  = 3'd6;

  localparam logic [1:0] ERR_CHAR     = 2'd0;
  localparam logic [1:0] ERR_ADDR     = 2'd1;
  localparam logic [1:0] ERR_TYPE     = 2'd2;
  localparam logic [1:0] ERR_INTERNAL = 2'd3;

  localparam logic [2:0] REG_SYNC  = 3'd0;
  localparam logic [2:0] REG_START = 3'd1;
  localparam logic [2:0] REG_END   = 3'd2;
  localparam logic [2:0] REG_ESC   = 3'd3;
  localparam logic [2:0] REG_OFFS  = 3'd4;
  localparam logic [2:0] REG_INIT  = 3'd5;
  localparam logic [2:0] REG_POLL  = 3'd6;
  localparam logic [2:0] REG_XMIT  = 3'd7;

  typedef struct packed {
    logic [7:0] sync_code;
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] address_offset;
    logic [7:0] init_code;
    logic [7:0] poll_code;
    logic [7:0] transmit_code;
  } cfg_t;

endpackage

// ===== rtl/core/cmri_stream_if.sv =====
// Valid/ready channels of the CMRI frame parser: received bytes in, parse results out.
// Depends on cmri_pkg for the position width.
interface cmri_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cmri_out_if import cmri_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [2:0]              event_res;
  logic [6:0]              board_address;
  logic [7:0]              data_byte;
  logic [1:0]              error_code;
  logic [POS_OUT_BITS-1:0] position;

  modport source (output valid, output event_res, output board_address, output data_byte,
                  output error_code, output position, input ready);
  modport sink (input valid, input event_res, input board_address, input data_byte,
                input error_code, input position, output ready);
endinterface

// ===== rtl/core/cmri_cfg_regs.sv =====
// APB-style configuration registers of the CMRI frame parser.
// Depends on cmri_pkg for the register indexes and the cfg_t struct.
module cmri_cfg_regs import cmri_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic [7:0] rd_val;
  logic       wr_en;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;
  assign prdata = {24'd0, rd_val};

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SYNC:  cfg_d.sync_code      = pwdata[7:0];
        REG_START: cfg_d.start_code     = pwdata[7:0];
        REG_END:   cfg_d.end_code       = pwdata[7:0];
        REG_ESC:   cfg_d.escape_code    = pwdata[7:0];
        REG_OFFS:  cfg_d.address_offset = pwdata[7:0];
        REG_INIT:  cfg_d.init_code      = pwdata[7:0];
        REG_POLL:  cfg_d.poll_code      = pwdata[7:0];
        REG_XMIT:  cfg_d.transmit_code  = pwdata[7:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYNC:  rd_val = cfg_q.sync_code;
      REG_START: rd_val = cfg_q.start_code;
      REG_END:   rd_val = cfg_q.end_code;
      REG_ESC:   rd_val = cfg_q.escape_code;
      REG_OFFS:  rd_val = cfg_q.address_offset;
      REG_INIT:  rd_val = cfg_q.init_code;
      REG_POLL:  rd_val = cfg_q.poll_code;
      REG_XMIT:  rd_val = cfg_q.transmit_code;
      default:   rd_val = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_code      <= 8'd255;
      cfg_q.start_code     <= 8'd2;
      cfg_q.end_code       <= 8'd3;
      cfg_q.escape_code    <= 8'd16;
      cfg_q.address_offset <= 8'd65;
      cfg_q.init_code      <= 8'd73;
      cfg_q.poll_code      <= 8'd80;
      cfg_q.transmit_code  <= 8'd84;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/cmri_parse_core.sv =====
// Byte input register, frame state machine and result register of the CMRI frame parser.
// Depends on cmri_pkg and on the cmri_in_if and cmri_out_if interfaces.
module cmri_parse_core import cmri_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  cmri_in_if.sink     rx_i,
  cmri_out_if.source  res_o
);

  localparam logic [2:0] PH_SYN1  = 3'd0;
  localparam logic [2:0] PH_SYN2  = 3'd1;
  localparam logic [2:0] PH_START = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_TYPE  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_RAW   = 3'd6;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic                     in_valid_q;
  logic [7:0]               in_byte_q;
  logic                     out_valid_q;
  logic [2:0]               ev_q, ev_d;
  logic [6:0]               addr_q, addr_d;
  logic [7:0]               data_q, data_d;
  logic [1:0]               err_q, err_d;
  logic [POS_OUT_BITS-1:0]  pos_out_q;
  logic [2:0]               phase_q, phase_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_inc;
  logic                     out_free, fire;
  logic [8:0]               span_hi;
  logic                     in_span;
  logic [7:0]               addr_diff;
  logic [7:0]               b;

  assign out_free = !out_valid_q || res_o.ready;
  assign fire     = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || fire;

  assign b         = in_byte_q;
  assign pos_inc   = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  assign span_hi   = {1'b0, cfg_i.address_offset} + 9'd127;
  assign in_span   = (b >= cfg_i.address_offset) && ({1'b0, b} <= span_hi);
  assign addr_diff = b - cfg_i.address_offset;

  always_comb begin
    ev_d    = EV_NONE;
    err_d   = ERR_CHAR;
    data_d  = 8'd0;
    addr_d  = addr_q;
    phase_d = phase_q;
    pos_d   = pos_inc;
    unique case (phase_q)
      PH_SYN1: begin
        if (b == cfg_i.sync_code) begin
          phase_d = PH_SYN2;
        end else begin
          ev_d = EV_ERR;
        end
      end
      PH_SYN2: begin
        if (b == cfg_i.sync_code) begin
          phase_d = PH_START;
        end else begin
          ev_d = EV_ERR;
        end
      end
      PH_START: begin
        if (b == cfg_i.start_code) begin
          phase_d = PH_ADDR;
        end else begin
          ev_d = EV_ERR;
        end
      end
      PH_ADDR: begin
        if (in_span) begin
          addr_d  = addr_diff[6:0];
          phase_d = PH_TYPE;
        end else begin
          ev_d  = EV_ERR;
          err_d = ERR_ADDR;
        end
      end
      PH_TYPE: begin
        priority if (b == cfg_i.init_code) begin
          ev_d    = EV_INIT;
          phase_d = PH_DATA;
        end else if (b == cfg_i.poll_code) begin
          ev_d    = EV_POLL;
          phase_d = PH_DATA;
        end else if (b == cfg_i.transmit_code) begin
          ev_d    = EV_XMIT;
          phase_d = PH_DATA;
        end else begin
          ev_d  = EV_ERR;
          err_d = ERR_TYPE;
        end
      end
      PH_DATA: begin
        priority if (b == cfg_i.escape_code) begin
          phase_d = PH_RAW;
        end else if (b == cfg_i.end_code) begin
          ev_d    = EV_END;
          pos_d   = '0;
          phase_d = PH_SYN1;
        end else if (b == cfg_i.sync_code || b == cfg_i.start_code) begin
          ev_d = EV_ERR;
        end else begin
          ev_d   = EV_DATA;
          data_d = b;
        end
      end
      PH_RAW: begin
        if (b == cfg_i.escape_code || b == cfg_i.end_code ||
            b == cfg_i.sync_code || b == cfg_i.start_code) begin
          ev_d    = EV_DATA;
          data_d  = b;
          phase_d = PH_DATA;
        end else begin
          ev_d = EV_ERR;
        end
      end
      default: begin
        ev_d    = EV_ERR;
        err_d   = ERR_INTERNAL;
        phase_d = PH_SYN1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_SYN1;
      pos_q       <= '0;
      addr_q      <= 7'd0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        addr_q  <= addr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (fire) begin
      ev_q      <= ev_d;
      data_q    <= data_d;
      err_q     <= (ev_d == EV_ERR) ? err_d : ERR_CHAR;
      pos_out_q <= POS_OUT_BITS'(pos_inc);
    end
  end

  logic [6:0] res_addr_q;
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_addr_q <= addr_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.event_res     = ev_q;
  assign res_o.board_address = res_addr_q;
  assign res_o.data_byte     = data_q;
  assign res_o.error_code    = err_q;
  assign res_o.position      = pos_out_q;

endmodule

// ===== rtl/core/cmri_frame_parser.sv =====
// CMRI serial frame parser: one received byte in, one parse result out per transaction.
// Each accepted byte waits in the input register until the result register is free; then its result is registered.
// Throughput: one byte per cycle while the result sink is ready; the result register drains while the next byte waits.
// Reset (rst_ni low, asynchronous) clears the frame phase, position, address and the valid flags of both stages.
// Depends on cmri_pkg, the stream interfaces, cmri_cfg_regs and cmri_parse_core.
`include "cmri_frame_parser_macros.svh"

module cmri_frame_parser import cmri_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cmri_in_if.sink              rx_i,
  cmri_out_if.source           res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t cfg;

  cmri_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cmri_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .rx_i   (rx_i),
    .res_o  (res_o)
  );

  `CMRI_ASSERT(a_err_code_only_on_error, res_o.valid && res_o.event_res != EV_ERR |-> res_o.error_code == ERR_CHAR, "error code set without an error event")
  `CMRI_ASSERT(a_data_only_on_data, res_o.valid && res_o.event_res != EV_DATA |-> res_o.data_byte == 8'd0, "data byte set without a data event")
  `CMRI_ASSERT(a_position_nonzero, res_o.valid |-> res_o.position != '0, "result position is zero")
  `CMRI_ASSERT_NORST(a_no_result_in_reset, !rst_ni |-> !res_o.valid, "result valid during reset")

endmodule
